[rtl/sert_pkg.sv]
// ----------------------------------------------------------------------------
// sert_pkg
// Shared types and constants of the stereo early-reflection tap block.
// ----------------------------------------------------------------------------
package sert_pkg;

  localparam int MIX_W    = 17;
  localparam int TAP_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic signed [15:0] WEIGHT_NEAR = 16'sd19661;
  localparam logic signed [15:0] WEIGHT_FAR  = 16'sd13107;

  localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ONE_LEFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TWO_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ONE_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TWO_RIGHT = 3'd4;

  typedef enum logic [1:0] {
    SEL_MEM,
    SEL_DRY,
    SEL_ZERO
  } tap_sel_t;

  typedef struct packed {
    logic     cap_one;
    logic     do_sum;
    logic     do_mix;
    tap_sel_t sel;
  } chan_ctrl_t;

endpackage

[rtl/sert_ram.sv]
// ----------------------------------------------------------------------------
// sert_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sert_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sert_channel.sv]
// ----------------------------------------------------------------------------
// sert_channel
// One channel: history memory, tap weighting, mix scaling and saturation.
// ----------------------------------------------------------------------------
module sert_channel
  import sert_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8192,
  parameter int SAMPLE_BITS   = 16,
  parameter int AW            = $clog2(HISTORY_DEPTH)
) (
  input  logic                          clk,
  input  chan_ctrl_t                    ctrl,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic signed [SAMPLE_BITS-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  input  logic signed [SAMPLE_BITS-1:0] dry,
  input  logic [MIX_W-1:0]              mix_gain,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int ER_W  = SAMPLE_BITS + 17;
  localparam int P_W   = ER_W + MIX_W + 1;
  localparam int WET_W = P_W - 31;
  localparam int SUM_W = WET_W + 1;
  localparam logic signed [P_W-1:0] RND_HALF = P_W'(64'sd1 <<< 30);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic [SAMPLE_BITS-1:0]        rdata;
  logic signed [SAMPLE_BITS-1:0] tap_val;
  logic signed [SAMPLE_BITS-1:0] tap_one;
  logic signed [ER_W-1:0]        er;
  logic signed [P_W-1:0]         p;
  logic signed [P_W-1:0]         p_rnd;
  logic signed [WET_W-1:0]       wet;
  logic signed [SUM_W-1:0]       total;

  sert_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(HISTORY_DEPTH),
    .AW   (AW)
  ) u_hist (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    case (ctrl.sel)
      SEL_DRY:  tap_val = dry;
      SEL_ZERO: tap_val = '0;
      default:  tap_val = $signed(rdata);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap_one) begin
      tap_one <= tap_val;
    end
    if (ctrl.do_sum) begin
      er <= ER_W'(tap_one) * ER_W'(WEIGHT_NEAR) + ER_W'(tap_val) * ER_W'(WEIGHT_FAR);
    end
    if (ctrl.do_mix) begin
      p <= P_W'(er) * P_W'($signed({1'b0, mix_gain}));
    end
  end

  always_comb begin
    p_rnd = p + RND_HALF;
    wet   = WET_W'(p_rnd >>> 31);
    total = SUM_W'(dry) + SUM_W'(wet);
    if (total > SAT_HI) begin
      result = SAMPLE_BITS'(SAT_HI);
    end else if (total < SAT_LO) begin
      result = SAMPLE_BITS'(SAT_LO);
    end else begin
      result = SAMPLE_BITS'(total);
    end
  end

endmodule

[rtl/stereo_early_reflection_taps.sv]
// ----------------------------------------------------------------------------
// stereo_early_reflection_taps
// Two-tap early-reflection stage for stereo frames.
// ----------------------------------------------------------------------------
// Each input item is one stereo frame; each output item is the processed frame
// with its end_of_block flag copied to block_end. Both channels use valid and
// ready. Configuration is written through cfg_write, cfg_index and cfg_data;
// the user must do this only while idle; the block itself does not enforce it.
// A frame with a nonzero mix gain is written to each channel's history RAM in
// the cycle it is accepted, the two taps are then read one per cycle from the
// same RAM, weighted, scaled by the mix gain and added to the dry sample.
// Such an item passes through ST_TAP2, ST_SUM, ST_MIX and ST_OUT before it
// is loaded into the output register, and the next item is accepted only once
// the block is back in ST_IDLE, set by the two sequential tap reads of the
// single read port plus the sum, mix and output steps. With a zero mix gain
// a frame goes from acceptance straight to ST_OUT and then to the output
// register, the next item waits for ST_IDLE, and the history is left alone.
// Reset clears the configuration, the write position and the fill count. The
// history RAM is not swept; taps that reach beyond the frames written since
// reset read as zero. When the receiver stalls, the finished item waits in the
// output register and the block holds its next item in the output step.
// HISTORY_DEPTH must be a power of two.
module stereo_early_reflection_taps
  import sert_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8192,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_left,
  input  logic signed [SAMPLE_BITS-1:0] sample_right,
  input  logic                          end_of_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          block_end
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0] FULL = (AW + 1)'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP2,
    ST_SUM,
    ST_MIX,
    ST_OUT
  } state_t;

  state_t state;

  logic [MIX_W-1:0] mix_gain;
  logic [TAP_W-1:0] tap_one_left;
  logic [TAP_W-1:0] tap_two_left;
  logic [TAP_W-1:0] tap_one_right;
  logic [TAP_W-1:0] tap_two_right;

  logic [AW-1:0] wp;
  logic [AW:0]   fill;
  logic [AW:0]   fill_next;
  logic          bypass;
  logic          eob;
  logic signed [SAMPLE_BITS-1:0] dry_left;
  logic signed [SAMPLE_BITS-1:0] dry_right;
  tap_sel_t      sel_left;
  tap_sel_t      sel_right;

  logic          accept;
  logic          wr_en;
  logic          out_free;
  logic [AW-1:0] d_left;
  logic [AW-1:0] d_right;
  logic [AW-1:0] raddr_left;
  logic [AW-1:0] raddr_right;
  chan_ctrl_t    ctrl_left;
  chan_ctrl_t    ctrl_right;
  logic signed [SAMPLE_BITS-1:0] res_left;
  logic signed [SAMPLE_BITS-1:0] res_right;

  function automatic tap_sel_t pick_sel(logic [AW-1:0] d, logic [AW:0] filled);
    tap_sel_t s;
    if (d == '0) begin
      s = SEL_DRY;
    end else if ({1'b0, d} >= filled) begin
      s = SEL_ZERO;
    end else begin
      s = SEL_MEM;
    end
    return s;
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (mix_gain != '0);
  assign out_free = !out_valid || out_ready;
  assign fill_next = (fill == FULL) ? fill : fill + (AW + 1)'(1);

  always_comb begin
    if (state == ST_IDLE) begin
      d_left  = AW'(tap_one_left);
      d_right = AW'(tap_one_right);
    end else begin
      d_left  = AW'(tap_two_left);
      d_right = AW'(tap_two_right);
    end
    raddr_left  = wp - d_left;
    raddr_right = wp - d_right;

    ctrl_left.cap_one  = (state == ST_TAP2);
    ctrl_left.do_sum   = (state == ST_SUM);
    ctrl_left.do_mix   = (state == ST_MIX);
    ctrl_left.sel      = sel_left;
    ctrl_right.cap_one = (state == ST_TAP2);
    ctrl_right.do_sum  = (state == ST_SUM);
    ctrl_right.do_mix  = (state == ST_MIX);
    ctrl_right.sel     = sel_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_gain      <= '0;
      tap_one_left  <= '0;
      tap_two_left  <= '0;
      tap_one_right <= '0;
      tap_two_right <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIX_GAIN:      mix_gain      <= MIX_W'(cfg_data);
        REG_TAP_ONE_LEFT:  tap_one_left  <= TAP_W'(cfg_data);
        REG_TAP_TWO_LEFT:  tap_two_left  <= TAP_W'(cfg_data);
        REG_TAP_ONE_RIGHT: tap_one_right <= TAP_W'(cfg_data);
        REG_TAP_TWO_RIGHT: tap_two_right <= TAP_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            dry_left  <= sample_left;
            dry_right <= sample_right;
            eob       <= end_of_block;
            bypass    <= (mix_gain == '0);
            sel_left  <= pick_sel(d_left, fill_next);
            sel_right <= pick_sel(d_right, fill_next);
            state     <= (mix_gain == '0) ? ST_OUT : ST_TAP2;
          end
        end
        ST_TAP2: begin
          sel_left  <= pick_sel(d_left, fill_next);
          sel_right <= pick_sel(d_right, fill_next);
          state     <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_MIX;
        end
        ST_MIX: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_left  <= bypass ? dry_left : res_left;
            out_right <= bypass ? dry_right : res_right;
            block_end <= eob;
            if (!bypass) begin
              wp   <= wp + AW'(1);
              fill <= fill_next;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sert_channel #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .AW           (AW)
  ) u_left (
    .clk     (clk),
    .ctrl    (ctrl_left),
    .we      (wr_en),
    .waddr   (wp),
    .wdata   (sample_left),
    .raddr   (raddr_left),
    .dry     (dry_left),
    .mix_gain(mix_gain),
    .result  (res_left)
  );

  sert_channel #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .AW           (AW)
  ) u_right (
    .clk     (clk),
    .ctrl    (ctrl_right),
    .we      (wr_en),
    .waddr   (wp),
    .wdata   (sample_right),
    .raddr   (raddr_right),
    .dry     (dry_right),
    .mix_gain(mix_gain),
    .result  (res_right)
  );

endmodule

[rtl/sert_checker.sv]
// ----------------------------------------------------------------------------
// sert_checker
// Port-level checks of item flow for the early-reflection tap block.
// ----------------------------------------------------------------------------
module sert_checker
  import sert_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_left,
  input logic signed [SAMPLE_BITS-1:0] out_right,
  input logic                          block_end
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) pending != 2'd3)
    else $error("more than two items in flight");

  a_no_invented: assert property (@(posedge clk) disable iff (rst) out_valid |-> pending != 2'd0)
    else $error("output item without an accepted input item");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst) in_acc |=> !in_ready)
    else $error("input accepted while an item is still in work");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({out_left, out_right, block_end}))
    else $error("stalled output item changed");

endmodule

bind stereo_early_reflection_taps sert_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sert_checker (.*);
